FILE: design/lgs_pkg.sv
// ---------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation step block.
// ---------------------------------------------------------------------------
package lgs_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int ACT_W   = 2;
    localparam int CROW_W  = 6;
    localparam int CCOL_W  = 6;
    localparam int CNT_W   = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;

    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;

    localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 7'd64;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ADDR_CELL  = 2'd0,
        ADDR_ROW0  = 2'd1,
        ADDR_ROW1  = 2'd2,
        ADDR_AHEAD = 2'd3
    } t_addr_sel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_RD,
        S_CELL_WB,
        S_PRIME0,
        S_PRIME1,
        S_LOAD,
        S_CALC,
        S_COUNT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic      in_ready;
        logic      start;
        logic      rd_en;
        t_addr_sel addr_sel;
        logic      cell_wb;
        logic      load_cur;
        logic      load_nxt;
        logic      calc;
        logic      count;
        logic      advance;
        logic      clr_wr;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic    in_valid;
        t_action action;
        logic    clr_done;
        logic    col_last;
        logic    row_last;
        logic    out_free;
    } t_stat;

endpackage

FILE: design/lgs_if.sv
// ---------------------------------------------------------------------------
// lgs interfaces
// Valid/ready channels for items, results and configuration writes.
// ---------------------------------------------------------------------------
interface lgs_in_if import lgs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [CROW_W-1:0] cell_row;
    logic [CCOL_W-1:0] cell_col;
    logic              cell_value;
    modport source (output valid, action, cell_row, cell_col, cell_value, input ready);
    modport sink   (input valid, action, cell_row, cell_col, cell_value, output ready);
endinterface

interface lgs_out_if import lgs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cell_out;
    logic [CNT_W-1:0] changed_count;
    logic             stable;
    modport source (output valid, cell_out, changed_count, stable, input ready);
    modport sink   (input valid, cell_out, changed_count, stable, output ready);
endinterface

interface lgs_cfg_if import lgs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/lgs_datapath.sv
// ---------------------------------------------------------------------------
// lgs_datapath
// Row-wide grid memory, three-row window, next-row logic and change counter.
// ---------------------------------------------------------------------------
module lgs_datapath import lgs_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    lgs_in_if.sink      i_in,
    lgs_out_if.source   o_out,
    lgs_cfg_if.sink     i_cfg
);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW1 = $clog2(MAX_ROWS + 1);
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW1 = $clog2(MAX_COLS + 1);
    localparam int KH  = (RW1 > CFG_DATA_W) ? RW1 : CFG_DATA_W;
    localparam int KC  = (CW1 > CFG_DATA_W) ? CW1 : CFG_DATA_W;
    localparam int KRI = (RW1 > CROW_W) ? RW1 : CROW_W;
    localparam int KCI = (CW1 > CCOL_W) ? CW1 : CCOL_W;

    logic [MAX_COLS-1:0] mem [MAX_ROWS];

    logic [CFG_DATA_W-1:0] r_width, r_height;
    logic [CW1-1:0]        w_eff;
    logic [RW1-1:0]        h_eff;

    t_action           r_act;
    logic [CROW_W-1:0] r_crow;
    logic [CCOL_W-1:0] r_ccol;
    logic              r_cval;
    logic              r_inside;

    logic [RW1-1:0]      r_row;
    logic [CW-1:0]       r_col;
    logic [MAX_COLS-1:0] r_rd_data;
    logic [MAX_COLS-1:0] r_prev, r_cur, r_nxt, r_diff;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_cell;
    logic                r_out_valid, r_out_cell, r_out_stable;
    logic [CNT_W-1:0]    r_out_cnt;

    logic [RW-1:0]       rd_addr, wr_addr;
    logic [MAX_COLS-1:0] wr_data, cell_row_new, col_mask, new_row;
    logic                wr_en;
    logic [RW1:0]        row_ahead, row_plus1;
    logic                inside_in;

    // effective sizes, clamped to 1..max
    always_comb begin
        if (r_width == '0) begin
            w_eff = CW1'(1);
        end else if (KC'(r_width) > KC'(MAX_COLS)) begin
            w_eff = CW1'(MAX_COLS);
        end else begin
            w_eff = CW1'(r_width);
        end
        if (r_height == '0) begin
            h_eff = RW1'(1);
        end else if (KH'(r_height) > KH'(MAX_ROWS)) begin
            h_eff = RW1'(MAX_ROWS);
        end else begin
            h_eff = RW1'(r_height);
        end
    end

    assign inside_in = (KRI'(i_in.cell_row) < KRI'(h_eff)) &&
                       (KCI'(i_in.cell_col) < KCI'(w_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= GRID_SIZE_RESET;
            r_height <= GRID_SIZE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_GRID_WIDTH:  r_width  <= i_cfg.data;
                REG_GRID_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    // column mask of the active region
    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = (CW1'(c) < w_eff);
        end
    end

    // next generation of the current row, hidden columns kept
    always_comb begin
        logic [MAX_COLS+1:0] a, b, d;
        logic [3:0]          n;
        a = {1'b0, r_prev & col_mask, 1'b0};
        b = {1'b0, r_cur  & col_mask, 1'b0};
        d = {1'b0, r_nxt  & col_mask, 1'b0};
        for (int c = 0; c < MAX_COLS; c++) begin
            n = 4'(a[c]) + 4'(a[c+1]) + 4'(a[c+2]) + 4'(b[c]) + 4'(b[c+2])
              + 4'(d[c]) + 4'(d[c+1]) + 4'(d[c+2]);
            if (!col_mask[c]) begin
                new_row[c] = r_cur[c];
            end else if (n == 4'd3) begin
                new_row[c] = 1'b1;
            end else if (n == 4'd2) begin
                new_row[c] = r_cur[c];
            end else begin
                new_row[c] = 1'b0;
            end
        end
    end

    assign row_ahead = (RW1+1)'(r_row) + (RW1+1)'(2);
    assign row_plus1 = (RW1+1)'(r_row) + (RW1+1)'(1);

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_CELL:  rd_addr = RW'(r_crow);
            ADDR_ROW0:  rd_addr = '0;
            ADDR_ROW1:  rd_addr = RW'(1);
            ADDR_AHEAD: rd_addr = row_ahead[RW-1:0];
            default:    rd_addr = '0;
        endcase
    end

    always_comb begin
        cell_row_new = r_rd_data;
        cell_row_new[CW'(r_ccol)] = r_cval;
        wr_en   = 1'b0;
        wr_addr = r_row[RW-1:0];
        wr_data = '0;
        if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.calc) begin
            wr_en   = 1'b1;
            wr_data = new_row;
        end else if (i_cmd.cell_wb && r_act == ACT_WRITE && r_inside) begin
            wr_en   = 1'b1;
            wr_addr = RW'(r_crow);
            wr_data = cell_row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // window, counters and latched item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_row <= r_row + RW1'(1);
            end else if (i_cmd.start) begin
                r_row <= '0;
            end else if (i_cmd.advance) begin
                r_row <= r_row + RW1'(1);
            end
            if (i_cmd.calc) begin
                r_col <= '0;
            end else if (i_cmd.count) begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_act    <= t_action'(i_in.action);
            r_crow   <= i_in.cell_row;
            r_ccol   <= i_in.cell_col;
            r_cval   <= i_in.cell_value;
            r_inside <= inside_in;
            r_cnt    <= '0;
            r_cell   <= 1'b0;
        end
        if (i_cmd.cell_wb && r_act == ACT_READ) begin
            r_cell <= r_inside & r_rd_data[CW'(r_ccol)];
        end
        if (i_cmd.load_cur) begin
            r_prev <= '0;
            r_cur  <= r_rd_data;
        end
        if (i_cmd.load_nxt) begin
            r_nxt <= (row_plus1 < (RW1+1)'(h_eff)) ? r_rd_data : '0;
        end
        if (i_cmd.calc) begin
            r_diff <= (new_row ^ r_cur) & col_mask;
        end
        if (i_cmd.count && r_diff[r_col] && r_cnt != COUNT_MAX) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.advance) begin
            r_prev <= r_cur;
            r_cur  <= r_nxt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cell   <= r_cell;
            r_out_cnt    <= r_cnt;
            r_out_stable <= (r_act == ACT_STEP) && (r_cnt == '0);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.cell_out      = r_out_cell;
    assign o_out.changed_count = r_out_cnt;
    assign o_out.stable        = r_out_stable;
    assign i_in.ready          = i_cmd.in_ready;

    assign o_stat.in_valid = i_in.valid;
    assign o_stat.action   = t_action'(i_in.action);
    assign o_stat.clr_done = (r_row == RW1'(MAX_ROWS - 1));
    assign o_stat.col_last = ({1'b0, r_col} == (CW+1)'(w_eff - CW1'(1)));
    assign o_stat.row_last = (r_row == h_eff - RW1'(1));
    assign o_stat.out_free = !r_out_valid || o_out.ready;

endmodule

FILE: design/lgs_ctrl.sv
// ---------------------------------------------------------------------------
// lgs_ctrl
// Sequencer for clearing, cell access and the row-by-row generation sweep.
// ---------------------------------------------------------------------------
module lgs_ctrl import lgs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    case (i_stat.action)
                        ACT_WRITE, ACT_READ: n_state = S_CELL_RD;
                        ACT_STEP:            n_state = S_PRIME0;
                        default:             n_state = S_FINISH;
                    endcase
                end
            end
            S_CELL_RD: n_state = S_CELL_WB;
            S_CELL_WB: n_state = S_FINISH;
            S_PRIME0:  n_state = S_PRIME1;
            S_PRIME1:  n_state = S_LOAD;
            S_LOAD:    n_state = S_CALC;
            S_CALC:    n_state = S_COUNT;
            S_COUNT: begin
                if (i_stat.col_last) begin
                    n_state = i_stat.row_last ? S_FINISH : S_LOAD;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.addr_sel = ADDR_CELL;
        case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.start    = i_stat.in_valid;
            end
            S_CELL_RD: o_cmd.rd_en = 1'b1;
            S_CELL_WB: o_cmd.cell_wb = 1'b1;
            S_PRIME0: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = ADDR_ROW0;
            end
            S_PRIME1: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = ADDR_ROW1;
                o_cmd.load_cur = 1'b1;
            end
            S_LOAD: o_cmd.load_nxt = 1'b1;
            S_CALC: o_cmd.calc = 1'b1;
            S_COUNT: begin
                o_cmd.count = 1'b1;
                // end of row: fetch the row two below and slide the window
                if (i_stat.col_last && !i_stat.row_last) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = ADDR_AHEAD;
                    o_cmd.advance  = 1'b1;
                end
            end
            S_FINISH: o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

FILE: design/life_generation_step.sv
// ---------------------------------------------------------------------------
// life_generation_step
// Bounded B3/S23 cell grid with cell write, cell read and generation step.
// ---------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_in      in   valid/ready     action, cell_row, cell_col, cell_value
//  o_out     out  valid/ready     cell_out, changed_count, stable
//  i_cfg     in   valid/ready     index, data (always ready)
//
//  write and read: S_CELL_RD, S_CELL_WB, then S_FINISH loads the result; the
//  unused code 3 goes straight to S_FINISH; the next item is taken in S_IDLE
//  step: S_PRIME0 and S_PRIME1 fill the three-row window, then each row runs
//  S_LOAD, S_CALC and S_COUNT, the change counter walking one column per cycle
//  after reset a clearing pass over all MAX_ROWS rows runs before i_in is ready
//  a held result in o_out stalls only the end of the next item
// ---------------------------------------------------------------------------
module life_generation_step import lgs_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lgs_in_if.sink    i_in,
    lgs_out_if.source o_out,
    lgs_cfg_if.sink   i_cfg
);
    t_cmd  cmd;
    t_stat stat;

    lgs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lgs_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

endmodule

FILE: design/lgs_checker.sv
// ---------------------------------------------------------------------------
// lgs_port_props
// Port-level checks on the life generation step block.
// ---------------------------------------------------------------------------
module lgs_port_props import lgs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic             cell_out,
    input logic [CNT_W-1:0] changed_count,
    input logic             stable,
    input logic             cfg_ready
);
    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");

    a_stable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && stable |-> changed_count == '0)
        else $error("stable with changes");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && cell_out |-> changed_count == '0 && !stable)
        else $error("read result mixed with step result");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind life_generation_step lgs_port_props u_lgs_port_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .in_valid      (i_in.valid),
    .in_ready      (i_in.ready),
    .out_valid     (o_out.valid),
    .out_ready     (o_out.ready),
    .cell_out      (o_out.cell_out),
    .changed_count (o_out.changed_count),
    .stable        (o_out.stable),
    .cfg_ready     (i_cfg.ready)
);
